@@ sv/bra_pkg.sv @@
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and codes for the boot region allocator: transaction payloads,
// opcodes, status codes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int FIELD_W = 48;

  typedef enum logic [1:0] {
    OP_ADD_AVAIL = 2'd0,
    OP_ADD_RESV  = 2'd1,
    OP_ALLOC     = 2'd2,
    OP_QUERY     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOFIT = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [FIELD_W-1:0] region_base;
    logic [FIELD_W-1:0] region_size;
    logic [5:0]         align_log2;
    logic [FIELD_W-1:0] query_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] alloc_address;
    logic               is_reserved;
    logic [FIELD_W-1:0] span_start;
    logic [FIELD_W-1:0] span_end;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_ADD_CHK,
    S_ADD_RD,
    S_ADD_EL,
    S_Q_RD,
    S_Q_CK,
    S_ALC_A,
    S_ALC_AW,
    S_ALC_G,
    S_ALC_GW,
    S_EV1,
    S_EV2,
    S_EV3,
    S_FIN
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    take_fit;
    logic    add_init;
    logic    rd_tgt;
    logic    add_new;
    logic    add_old;
    logic    add_flush;
    logic    r_inc;
    logic    rd_avail;
    logic    avail_load;
    logic    rd_resv;
    logic    gap_load;
    logic    ev1;
    logic    ev2;
    logic    gap_next;
    logic    res_set;
    status_t res_status;
    logic    res_addr;
    logic    res_resv;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    full;
    logic    r_end;
    logic    ins;
    logic    new_first;
    logic    q_below;
    logic    q_in;
    logic    a_end;
    logic    g_end;
    logic    fit;
    logic    size_zero;
  } stat_t;

endpackage

@@ sv/bra_ram.sv @@
// ----------------------------------------------------------------------------
// bra_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bra_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bra_dp.sv @@
// ----------------------------------------------------------------------------
// bra_dp
// Datapath: region tables in RAM, counts, request registers, the streaming
// insert/merge unit, the gap evaluation pipeline and the result registers.
// ----------------------------------------------------------------------------
module bra_dp
  import bra_pkg::*;
#(
  parameter int MAX_REGIONS = 32,
  parameter int ADDR_BITS   = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output stat_t     stat,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  localparam int AW = ADDR_BITS;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int IW = $clog2(MAX_REGIONS);
  localparam logic [AW-1:0] MASK = {AW{1'b1}};
  localparam logic [CW-1:0] MAXC = CW'(MAX_REGIONS);

  // request
  opcode_t     op_r;
  logic        tsel_r;               // 1: reserved table
  logic [AW-1:0] nb_r, ne_r, size_r, q_r;
  logic [5:0]  al_r;

  logic [CW-1:0] avail_cnt_r, resv_cnt_r;
  logic [CW-1:0] r_r, w_r, a_r, g_r;
  logic          ins_r, have_r;
  logic [AW-1:0] cur_b_r, cur_e_r;

  // allocation search
  logic [AW-1:0] s_r, e_r, gs_r, ge_r, gnext_r, ms_r, me_r, st_r;
  logic          skip_r;

  logic [1:0]    res_status_r;
  logic [AW-1:0] res_addr_r;
  logic          res_resv_r;
  logic [AW-1:0] span_s_r, span_e_r;
  out_item_t     out_r;

  // RAMs
  logic [2*AW-1:0] av_rd, rs_rd, wdata;
  logic            av_we, rs_we, av_re, rs_re;
  logic [IW-1:0]   av_ra, rs_ra;

  bra_ram #(.WIDTH(2 * AW), .DEPTH(MAX_REGIONS)) u_avail (
    .clk(clk), .we(av_we), .waddr(w_r[IW-1:0]), .wdata(wdata),
    .re(av_re), .raddr(av_ra), .rdata(av_rd)
  );

  bra_ram #(.WIDTH(2 * AW), .DEPTH(MAX_REGIONS)) u_resv (
    .clk(clk), .we(rs_we), .waddr(w_r[IW-1:0]), .wdata(wdata),
    .re(rs_re), .raddr(rs_ra), .rdata(rs_rd)
  );

  logic [2*AW-1:0] tgt_rd;
  logic [AW-1:0]   rd_b, rd_e;
  logic [CW-1:0]   tgt_cnt;

  assign tgt_rd  = tsel_r ? rs_rd : av_rd;
  assign rd_b    = tgt_rd[2*AW-1:AW];
  assign rd_e    = tgt_rd[AW-1:0];
  assign tgt_cnt = tsel_r ? resv_cnt_r : avail_cnt_r;

  assign av_re = (cmd.rd_tgt && !tsel_r) || cmd.rd_avail;
  assign rs_re = (cmd.rd_tgt && tsel_r) || cmd.rd_resv;
  assign av_ra = cmd.rd_avail ? a_r[IW-1:0] : r_r[IW-1:0];
  assign rs_ra = cmd.rd_resv ? g_r[IW-1:0] : r_r[IW-1:0];

  // field width conversion
  logic [AW+FIELD_W-1:0] base_x, size_x, q_x;
  assign base_x = {{AW{1'b0}}, in_data.region_base};
  assign size_x = {{AW{1'b0}}, in_data.region_size};
  assign q_x    = {{AW{1'b0}}, in_data.query_address};

  // end of region, clipped to the top of the address space
  logic [AW-1:0] re_base, re_size, re_end;
  logic [AW:0]   re_sum;
  assign re_base = cmd.take_fit ? st_r : base_x[AW-1:0];
  assign re_size = cmd.take_fit ? size_r : size_x[AW-1:0];
  assign re_sum  = {1'b0, re_base} + {1'b0, re_size};
  assign re_end  = re_sum[AW] ? MASK : re_sum[AW-1:0];

  // streaming merge: one element against the running entry
  logic [AW-1:0] x_b, x_e, lo, hi, mb, me;
  logic          ov, elem, wr;
  assign x_b  = cmd.add_new ? nb_r : rd_b;
  assign x_e  = cmd.add_new ? ne_r : rd_e;
  assign lo   = (cur_b_r > x_b) ? cur_b_r : x_b;
  assign hi   = (cur_e_r < x_e) ? cur_e_r : x_e;
  assign ov   = lo < hi;
  assign mb   = (cur_b_r < x_b) ? cur_b_r : x_b;
  assign me   = (cur_e_r > x_e) ? cur_e_r : x_e;
  assign elem = cmd.add_new || cmd.add_old;
  assign wr   = (elem && have_r && !ov) || cmd.add_flush;
  assign wdata = {cur_b_r, cur_e_r};
  assign av_we = wr && !tsel_r;
  assign rs_we = wr && tsel_r;

  // alignment
  logic [AW-1:0] amask, top;
  logic          aligned, nonempty;
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      amask[i] = (7'(i) < {1'b0, al_r});
    end
  end
  assign aligned  = (ms_r & amask) == '0;
  assign top      = ms_r | amask;
  assign nonempty = ms_r < me_r;

  logic fit;
  assign fit = !skip_r && (st_r < me_r) && ((me_r - st_r) >= size_r);

  always_comb begin
    stat.op        = op_r;
    stat.full      = tgt_cnt == MAXC;
    stat.r_end     = r_r == tgt_cnt;
    stat.ins       = ins_r;
    stat.new_first = nb_r <= rd_b;
    stat.q_below   = q_r < rs_rd[2*AW-1:AW];
    stat.q_in      = q_r < rs_rd[AW-1:0];
    stat.a_end     = a_r == avail_cnt_r;
    stat.g_end     = g_r == resv_cnt_r;
    stat.fit       = fit;
    stat.size_zero = size_r == '0;
  end

  function automatic logic [FIELD_W-1:0] wide48(input logic [AW-1:0] v);
    logic [AW+FIELD_W-1:0] t;
    t = {{FIELD_W{1'b0}}, v};
    return t[FIELD_W-1:0];
  endfunction

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_cnt_r <= '0;
      resv_cnt_r  <= '0;
      span_s_r    <= '0;
      span_e_r    <= '0;
      ins_r       <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      if (cmd.add_init) begin
        ins_r  <= 1'b0;
        have_r <= 1'b0;
      end
      if (elem) begin
        have_r <= 1'b1;
      end
      if (cmd.add_new) begin
        ins_r <= 1'b1;
      end
      if (wr && !tsel_r && w_r == '0) begin
        span_s_r <= cur_b_r;
      end
      if (cmd.add_flush) begin
        if (tsel_r) begin
          resv_cnt_r <= w_r + CW'(1);
        end else begin
          avail_cnt_r <= w_r + CW'(1);
          span_e_r    <= cur_e_r;
        end
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r   <= opcode_t'(in_data.opcode);
      tsel_r <= opcode_t'(in_data.opcode) != OP_ADD_AVAIL;
      nb_r   <= base_x[AW-1:0];
      ne_r   <= re_end;
      size_r <= size_x[AW-1:0];
      q_r    <= q_x[AW-1:0];
      al_r   <= in_data.align_log2;
      r_r    <= '0;
      a_r    <= '0;
      res_status_r <= ST_OK;
      res_addr_r   <= '0;
      res_resv_r   <= 1'b0;
    end
    if (cmd.take_fit) begin
      nb_r   <= st_r;
      ne_r   <= re_end;
      tsel_r <= 1'b1;
    end
    if (cmd.add_init) begin
      r_r <= '0;
      w_r <= '0;
    end
    if (elem) begin
      if (!have_r) begin
        cur_b_r <= x_b;
        cur_e_r <= x_e;
      end else if (ov) begin
        cur_b_r <= mb;
        cur_e_r <= me;
      end else begin
        cur_b_r <= x_b;
        cur_e_r <= x_e;
        w_r     <= w_r + CW'(1);
      end
    end
    if (cmd.add_old || cmd.r_inc) begin
      r_r <= r_r + CW'(1);
    end
    if (cmd.avail_load) begin
      s_r  <= av_rd[2*AW-1:AW];
      e_r  <= av_rd[AW-1:0];
      g_r  <= '0;
      gs_r <= '0;
    end
    if (cmd.gap_load) begin
      ge_r    <= stat.g_end ? MASK : rs_rd[2*AW-1:AW];
      gnext_r <= rs_rd[AW-1:0];
    end
    if (cmd.ev1) begin
      ms_r <= (s_r > gs_r) ? s_r : gs_r;
      me_r <= (e_r < ge_r) ? e_r : ge_r;
    end
    if (cmd.ev2) begin
      st_r   <= aligned ? ms_r : top + AW'(1);
      skip_r <= !nonempty || (!aligned && top == MASK);
    end
    if (cmd.gap_next) begin
      if (stat.g_end) begin
        a_r <= a_r + CW'(1);
      end else begin
        gs_r <= gnext_r;
        g_r  <= g_r + CW'(1);
      end
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
    end
    if (cmd.res_addr) begin
      res_addr_r <= nb_r;
    end
    if (cmd.res_resv) begin
      res_resv_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_r <= out_item_t'{
        status:        res_status_r,
        alloc_address: wide48(res_addr_r),
        is_reserved:   res_resv_r,
        span_start:    wide48(span_s_r),
        span_end:      wide48(span_e_r)
      };
    end
  end

  assign out_data = out_r;

endmodule

@@ sv/bra_ctrl.sv @@
// ----------------------------------------------------------------------------
// bra_ctrl
// Controller: sequences add/merge, query and first-fit allocate over the
// datapath and runs the input and result handshakes.
// ----------------------------------------------------------------------------
module bra_ctrl
  import bra_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.res_status = ST_OK;
    state_nxt     = state_r;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.op)
          OP_ADD_AVAIL, OP_ADD_RESV: state_nxt = S_ADD_CHK;
          OP_ALLOC: begin
            if (stat.size_zero) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_ZERO;
              state_nxt      = S_FIN;
            end else begin
              state_nxt = S_ALC_A;
            end
          end
          OP_QUERY: state_nxt = S_Q_RD;
        endcase
      end
      S_ADD_CHK: begin
        if (stat.full) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_FULL;
          state_nxt      = S_FIN;
        end else begin
          cmd.add_init = 1'b1;
          state_nxt    = S_ADD_RD;
        end
      end
      S_ADD_RD: begin
        if (stat.r_end) begin
          if (!stat.ins) begin
            cmd.add_new = 1'b1;
          end else begin
            cmd.add_flush = 1'b1;
            cmd.res_addr  = stat.op == OP_ALLOC;
            state_nxt     = S_FIN;
          end
        end else begin
          cmd.rd_tgt = 1'b1;
          state_nxt  = S_ADD_EL;
        end
      end
      S_ADD_EL: begin
        // new region goes in front of the first entry not below it
        if (!stat.ins && stat.new_first) begin
          cmd.add_new = 1'b1;
        end else begin
          cmd.add_old = 1'b1;
          state_nxt   = S_ADD_RD;
        end
      end
      S_Q_RD: begin
        if (stat.r_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_tgt = 1'b1;
          state_nxt  = S_Q_CK;
        end
      end
      S_Q_CK: begin
        priority if (stat.q_below) begin
          state_nxt = S_FIN;
        end else if (stat.q_in) begin
          cmd.res_resv = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          cmd.r_inc = 1'b1;
          state_nxt = S_Q_RD;
        end
      end
      S_ALC_A: begin
        if (stat.a_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOFIT;
          state_nxt      = S_FIN;
        end else begin
          cmd.rd_avail = 1'b1;
          state_nxt    = S_ALC_AW;
        end
      end
      S_ALC_AW: begin
        cmd.avail_load = 1'b1;
        state_nxt      = S_ALC_G;
      end
      S_ALC_G: begin
        // gap above the last reserved entry needs no read
        cmd.rd_resv = !stat.g_end;
        state_nxt   = S_ALC_GW;
      end
      S_ALC_GW: begin
        cmd.gap_load = 1'b1;
        state_nxt    = S_EV1;
      end
      S_EV1: begin
        cmd.ev1   = 1'b1;
        state_nxt = S_EV2;
      end
      S_EV2: begin
        cmd.ev2   = 1'b1;
        state_nxt = S_EV3;
      end
      S_EV3: begin
        if (stat.fit) begin
          cmd.take_fit = 1'b1;
          state_nxt    = S_ADD_CHK;
        end else begin
          cmd.gap_next = 1'b1;
          state_nxt    = stat.g_end ? S_ALC_A : S_ALC_G;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/boot_region_allocator_top.sv @@
// ----------------------------------------------------------------------------
// boot_region_allocator_top
// Add walks every stored entry of its table; query walks the reserved entries
// until it passes the address; allocate tries up to avail x (reserved + 1) gaps,
// then an add. One transaction at a time, set by the sequential walk over the
// single read port of each table RAM.
// Reset (rst_n, synchronous) empties both tables; table RAMs are not cleared.
// ----------------------------------------------------------------------------
module boot_region_allocator_top
  import bra_pkg::*;
#(
  parameter int MAX_REGIONS = 32,
  parameter int ADDR_BITS   = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  bra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  bra_dp #(.MAX_REGIONS(MAX_REGIONS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .stat(stat),
    .in_data(in_data), .out_data(out_data)
  );

endmodule

@@ tb/boot_region_allocator_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boot_region_allocator_top_tb
// Drives add/allocate/query transactions with random gaps and stalls, predicts
// each result with a behavioral copy of both region tables and checks every
// field in order.
// ----------------------------------------------------------------------------
module boot_region_allocator_top_tb;
  import bra_pkg::*;

  localparam int          NREG      = 32;
  localparam logic [63:0] AMASK     = 64'hFFFF_FFFF_FFFF;
  localparam int          WD_LIMIT  = 200000;
  localparam int          N_RANDOM  = 930;

  class region_scoreboard;
    logic [63:0] av_base[NREG], av_size[NREG], rs_base[NREG], rs_size[NREG];
    int av_n, rs_n;
    out_item_t pending[$];
    int errors, mism;

    function new();
      av_n = 0; rs_n = 0; errors = 0; mism = 0;
    endfunction

    function logic [63:0] clip_end(logic [63:0] b, logic [63:0] s);
      if (s > AMASK - b) return AMASK;
      return b + s;
    endfunction

    // insert sorted, then fold strictly overlapping neighbors
    function bit insert_region(bit to_avail, logic [63:0] b, logic [63:0] s);
      logic [63:0] tb[NREG], ts[NREG];
      int n, p, i, k;
      logic [63:0] ab, ae, bb, be, lo, hi;
      if (to_avail) begin tb = av_base; ts = av_size; n = av_n; end
      else begin tb = rs_base; ts = rs_size; n = rs_n; end
      if (n >= NREG) return 0;
      p = 0;
      while (p < n && b > tb[p]) p++;
      for (i = n; i > p; i--) begin tb[i] = tb[i-1]; ts[i] = ts[i-1]; end
      tb[p] = b; ts[p] = clip_end(b, s) - b; n++;
      i = 0;
      while (i + 1 < n) begin
        ab = tb[i]; ae = ab + ts[i]; bb = tb[i+1]; be = bb + ts[i+1];
        lo = (ab > bb) ? ab : bb; hi = (ae < be) ? ae : be;
        if (lo < hi) begin
          tb[i] = (ab < bb) ? ab : bb;
          ts[i] = ((ae > be) ? ae : be) - tb[i];
          for (k = i + 1; k + 1 < n; k++) begin tb[k] = tb[k+1]; ts[k] = ts[k+1]; end
          n--;
        end else i++;
      end
      if (to_avail) begin av_base = tb; av_size = ts; av_n = n; end
      else begin rs_base = tb; rs_size = ts; rs_n = n; end
      return 1;
    endfunction

    function bit first_fit(logic [63:0] nb, int al, output logic [63:0] where);
      logic [63:0] am, s, e, gs, ge, ms, me, st;
      am = (64'd1 << al) - 1;
      where = 0;
      for (int a = 0; a < av_n; a++) begin
        s = av_base[a]; e = s + av_size[a];
        for (int g = 0; g <= rs_n; g++) begin
          gs = g ? rs_base[g-1] + rs_size[g-1] : 64'd0;
          ge = (g == rs_n) ? AMASK : rs_base[g];
          ms = (s > gs) ? s : gs; me = (e < ge) ? e : ge;
          if (ms >= me) continue;
          if ((ms & am) == 0) st = ms;
          else begin
            if ((ms | am) >= AMASK) continue;
            st = (ms | am) + 1;
          end
          if (st >= me) continue;
          if (me - st >= nb) begin where = st; return 1; end
        end
      end
      return 0;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      logic [63:0] st, se;
      r = '0;
      case (opcode_t'(it.opcode))
        OP_ADD_AVAIL:
          if (!insert_region(1, 64'(it.region_base), 64'(it.region_size))) r.status = ST_FULL;
        OP_ADD_RESV:
          if (!insert_region(0, 64'(it.region_base), 64'(it.region_size))) r.status = ST_FULL;
        OP_ALLOC: begin
          if (it.region_size == 0) r.status = ST_ZERO;
          else if (!first_fit(64'(it.region_size), int'(it.align_log2), st))
            r.status = ST_NOFIT;
          else if (!insert_region(0, st, 64'(it.region_size))) r.status = ST_FULL;
          else r.alloc_address = st[47:0];
        end
        default: begin
          for (int i = 0; i < rs_n; i++) begin
            if (it.query_address < rs_base[i]) break;
            if (it.query_address - rs_base[i] < rs_size[i]) begin r.is_reserved = 1; break; end
          end
        end
      endcase
      if (av_n > 0) begin
        se = av_base[av_n-1] + av_size[av_n-1];
        r.span_start = av_base[0][47:0];
        r.span_end   = se[47:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t x;
      if (pending.size() == 0) begin
        errors++;
        if (mism++ < 10) $display("unexpected result %h", got);
        return;
      end
      x = pending.pop_front();
      if (got !== x) begin
        errors++;
        if (mism++ < 10)
          $display("mismatch: exp st=%0d ad=%h rs=%0b ss=%h se=%h / got st=%0d ad=%h rs=%0b ss=%h se=%h",
                   x.status, x.alloc_address, x.is_reserved, x.span_start, x.span_end,
                   got.status, got.alloc_address, got.is_reserved, got.span_start,
                   got.span_end);
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  region_scoreboard sb;
  int idle_cycles;
  bit long_hold;

  boot_region_allocator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 92) return int'($urandom_range(1, 4));
    return int'($urandom_range(20, 120));
  endfunction

  function logic [47:0] rnd48();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[47:0];
  endfunction

  function logic [47:0] small_addr();
    return 48'h1000 * 48'($urandom_range(0, 255)) + 48'($urandom_range(0, 4095));
  endfunction

  task automatic send_item(in_item_t it);
    in_valid <= 1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    @(negedge clk);
    in_valid <= 0;
    // valid goes low between transactions
    repeat (pick_gap() + 1) @(negedge clk);
  endtask

  task automatic send_fields(opcode_t op, logic [47:0] b, logic [47:0] s,
                             logic [5:0] al, logic [47:0] q);
    in_item_t it;
    it.opcode = op; it.region_base = b; it.region_size = s;
    it.align_log2 = al; it.query_address = q;
    send_item(it);
  endtask

  task automatic wait_drain();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic send_random();
    in_item_t it;
    int r;
    r = int'($urandom_range(0, 99));
    it.opcode = (r < 25) ? OP_ADD_AVAIL : (r < 45) ? OP_ADD_RESV : (r < 75) ? OP_ALLOC : OP_QUERY;
    it.align_log2 = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 47))
                                                : 6'($urandom_range(0, 12));
    if ($urandom_range(0, 9) == 0) begin
      it.region_base = rnd48(); it.region_size = rnd48(); it.query_address = rnd48();
    end else begin
      it.region_base = small_addr();
      it.region_size = ($urandom_range(0, 19) == 0) ? 48'd0 : 48'($urandom_range(1, 40000));
      it.query_address = small_addr();
    end
    send_item(it);
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps going
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 0;
    else if (long_hold) out_ready <= 0;
    else out_ready <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst_n = 0; in_valid = 0; in_data = '0; long_hold = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // empty tables
    send_fields(OP_QUERY, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
    send_fields(OP_ALLOC, 0, 16, 0, 0);
    send_fields(OP_ALLOC, 0, 0, 0, 0);
    send_fields(OP_ADD_AVAIL, 48'h1000, 48'h10000, 0, 0);
    send_fields(OP_ADD_AVAIL, 48'h8000, 48'h10000, 0, 0);
    send_fields(OP_ADD_AVAIL, 48'h50000, 0, 0, 0);
    send_fields(OP_ADD_AVAIL, 48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF, 0, 0);
    send_fields(OP_ADD_RESV, 48'h2000, 48'h100, 0, 0);
    send_fields(OP_ADD_RESV, 48'h2080, 48'h1000, 0, 0);
    send_fields(OP_ADD_RESV, 48'h4000, 0, 0, 0);
    send_fields(OP_ALLOC, 0, 48'h10, 6'd12, 0);
    send_fields(OP_ALLOC, 0, 48'h1, 6'd47, 0);
    send_fields(OP_ALLOC, 0, 48'hFFFF_FFFF_FFFF, 6'd0, 0);
    send_fields(OP_ALLOC, 0, 48'h100, 6'd40, 0);
    send_fields(OP_QUERY, 0, 0, 0, 48'h2000);
    send_fields(OP_QUERY, 0, 0, 0, 48'h3080);
    send_fields(OP_QUERY, 0, 0, 0, 48'h1FFF);
    send_fields(OP_QUERY, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
    // fill reserved table to force the full status
    for (int i = 0; i < 34; i++)
      send_fields(OP_ADD_RESV, 48'h100000 + 48'h100 * i, 48'h10, 0, 0);
    send_fields(OP_ALLOC, 0, 48'h8, 0, 0);
    send_fields(OP_QUERY, 0, 0, 0, 48'h100205);

    // sender pauses until the block is empty, then reset tables are not reachable,
    // so the remaining random run keeps the full state but mixes in all opcodes
    wait_drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 200) begin
        fork
          begin
            long_hold = 1;
            repeat (3000) @(negedge clk);
            long_hold = 0;
          end
        join_none
      end
      if (i == 500) wait_drain();
      send_random();
    end

    wait_drain();
    repeat (200) @(negedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
sv/bra_pkg.sv
sv/bra_ram.sv
sv/bra_dp.sv
sv/bra_ctrl.sv
sv/boot_region_allocator_top.sv
tb/boot_region_allocator_top_tb.sv
